// ===== rtl/lnmg_pkg.sv =====
`default_nettype none

package lnmg_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int LUMA_FRAC_DEF  = 16;
    localparam int MAX_HEIGHT     = 4096;

    localparam int OUT_COL_W      = 11;
    localparam int OUT_ROW_W      = 12;
    localparam int CFG_WIDTH_W    = 12;
    localparam int CFG_HEIGHT_W   = 13;
    localparam int GAIN_W         = 8;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_IDX_W      = 2;

    // gradient magnitude after gain scaling, 16 fraction bits
    localparam int VEC_W          = 20;
    localparam int RAD_W          = 42;
    localparam int LEN_W          = 21;
    localparam int Q_W            = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRADIENT_GAIN = 2'd2;

    localparam logic [CFG_WIDTH_W-1:0]  RST_WIDTH  = 12'd256;
    localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT = 13'd256;
    localparam logic [GAIN_W-1:0]       RST_GAIN   = 8'd48;

    // Rec.709 weights over 65536
    localparam logic [23:0] W_RED   = 24'd13933;
    localparam logic [23:0] W_GREEN = 24'd46871;
    localparam logic [23:0] W_BLUE  = 24'd4732;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0]           normal_x;
        logic [7:0]           normal_y;
        logic [7:0]           normal_z;
        logic [OUT_COL_W-1:0] out_column;
        logic [OUT_ROW_W-1:0] out_row;
        logic                 run_last;
    } t_pixel_out;

    typedef struct packed {
        logic [7:0] normal_x;
        logic [7:0] normal_y;
        logic [7:0] normal_z;
    } t_codes;

endpackage

`default_nettype wire

// ===== rtl/luminance_normal_map_generator.sv =====
`default_nettype none
// One pixel at a time; the next pixel is not accepted until this one has
// been written back to the line stores. Each normal it yields takes a
// 21-step square root plus three 17-step divisions in the shared
// normalize unit, and the pixel also waits while the receiver stalls.
// Reset clears counters, row window and registers (256, 256, 48). The line
// stores are not cleared and need no clearing pass.

module luminance_normal_map_generator #(
    parameter int MAX_WIDTH      = lnmg_pkg::MAX_WIDTH_DEF,
    parameter int LUMA_FRAC_BITS = lnmg_pkg::LUMA_FRAC_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire lnmg_pkg::t_pixel_in            i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output lnmg_pkg::t_pixel_out                o_out_data,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [lnmg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lnmg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lnmg_pkg::*;

    localparam int LW   = LUMA_FRAC_BITS;
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (AW + 1 > CFG_WIDTH_W) ? AW + 1 : CFG_WIDTH_W;
    localparam int K    = 32 - LW;

    typedef enum logic [3:0] {
        S_IDLE, S_LUMA, S_RD1, S_RD2, S_RD3, S_EMIT, S_WAIT, S_PUSH, S_WR1, S_WR2
    } t_state;

    t_state                  r_state;
    logic [CFG_WIDTH_W-1:0]  r_width;
    logic [CFG_HEIGHT_W-1:0] r_height;
    logic [GAIN_W-1:0]       r_gain;
    logic [AW-1:0]           r_col;
    logic [OUT_ROW_W-1:0]    r_row;
    logic [LW-1:0]           r_w0, r_w1;
    t_pixel_in               r_rgb;
    logic [LW-1:0]           r_lum, r_pc, r_oc, r_pl, r_pr;
    logic [2:0]              r_en;
    logic [1:0]              r_lastidx;
    logic [1:0]              r_eidx;
    logic                    r_ovalid;
    t_pixel_out              r_out;

    logic [CMPW-1:0]         w_ext;
    logic [AW-1:0]           ewm1;
    logic [OUT_ROW_W-1:0]    ehm1;
    logic                    eol, last;
    logic [AW-1:0]           cm1, rc;
    logic [AW:0]             cp1;
    logic [23:0]             lsum;
    logic [32:0]             lround, lfull;
    logic [LW-1:0]           lum;
    logic                    accept, load;

    logic [AW-1:0]           prior_raddr, mem_waddr;
    logic [LW-1:0]           prior_q, older_q, prior_wdata, older_wdata;
    logic                    mem_we;

    logic [LW-1:0]           op_left, op_right, op_up, op_down;
    logic [AW-1:0]           op_col;
    logic [OUT_ROW_W-1:0]    op_row;
    logic                    norm_start, norm_busy, norm_done;
    t_codes                  norm_codes;

    always_comb begin
        w_ext = CMPW'(r_width);
        if (w_ext < CMPW'(2)) begin
            ewm1 = AW'(1);
        end else if (w_ext > CMPW'(MAX_WIDTH)) begin
            ewm1 = AW'(MAX_WIDTH - 1);
        end else begin
            ewm1 = AW'(w_ext - CMPW'(1));
        end
        if (r_height < CFG_HEIGHT_W'(2)) begin
            ehm1 = OUT_ROW_W'(1);
        end else if (r_height > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
            ehm1 = OUT_ROW_W'(MAX_HEIGHT - 1);
        end else begin
            ehm1 = OUT_ROW_W'(r_height - CFG_HEIGHT_W'(1));
        end
        eol  = r_col >= ewm1;
        last = r_row >= ehm1;
        cm1  = (r_col == '0) ? '0 : r_col - AW'(1);
        cp1  = {1'b0, r_col} + (AW+1)'(1);
        rc   = (cp1 > {1'b0, ewm1}) ? ewm1 : cp1[AW-1:0];

        lsum   = W_RED * 24'(r_rgb.red) + W_GREEN * 24'(r_rgb.green)
               + W_BLUE * 24'(r_rgb.blue);
        // times 257, then round to LW fraction bits
        lround = {1'b0, lsum, 8'b0} + 33'(lsum) + (33'd1 << (K - 1));
        lfull  = lround >> K;
        lum    = lfull[LW] ? '1 : lfull[LW-1:0];
    end

    assign accept = i_in_valid && !o_in_stall;
    assign load   = (r_state == S_PUSH) && (!r_ovalid || !i_out_stall);

    // line store ports
    always_comb begin
        case (r_state)
            S_RD1:   prior_raddr = cm1;
            S_RD2:   prior_raddr = rc;
            default: prior_raddr = r_col;
        endcase
        mem_we      = 1'b0;
        mem_waddr   = r_col;
        prior_wdata = r_lum;
        older_wdata = r_pc;
        if (r_state == S_WR1) begin
            mem_we      = r_col != '0;
            mem_waddr   = cm1;
            prior_wdata = r_w0;
            older_wdata = r_pl;
        end else if (r_state == S_WR2) begin
            mem_we      = eol;
        end
    end

    lnmg_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_prior (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (prior_wdata),
        .i_raddr (prior_raddr),
        .o_rdata (prior_q)
    );

    lnmg_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_older (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (older_wdata),
        .i_raddr (r_col),
        .o_rdata (older_q)
    );

    // operands of the three possible normals of one pixel
    always_comb begin
        case (r_eidx)
            2'd0: begin
                // pixel above, previous row
                op_left  = r_pl;
                op_right = r_pr;
                op_up    = (r_row == OUT_ROW_W'(1)) ? r_pc : r_oc;
                op_down  = r_lum;
                op_col   = r_col;
                op_row   = r_row - OUT_ROW_W'(1);
            end
            2'd1: begin
                // last row, one column behind
                op_left  = (r_col == AW'(1)) ? r_w0 : r_w1;
                op_right = r_lum;
                op_up    = r_pl;
                op_down  = r_w0;
                op_col   = cm1;
                op_row   = r_row;
            end
            default: begin
                // last row, final column
                op_left  = (r_col == '0) ? r_lum : r_w0;
                op_right = r_lum;
                op_up    = r_pc;
                op_down  = r_lum;
                op_col   = r_col;
                op_row   = r_row;
            end
        endcase
    end

    assign norm_start = (r_state == S_EMIT) && r_en[r_eidx];

    lnmg_norm #(.LUMA_FRAC_BITS(LW)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_left  (op_left),
        .i_right (op_right),
        .i_up    (op_up),
        .i_down  (op_down),
        .i_gain  (r_gain),
        .o_busy  (norm_busy),
        .o_done  (norm_done),
        .o_codes (norm_codes)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_gain   <= RST_GAIN;
            r_col    <= '0;
            r_row    <= '0;
            r_w0     <= '0;
            r_w1     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:   r_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT:  r_height <= i_cfg_data;
                    CFG_GRADIENT_GAIN: r_gain   <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (r_ovalid && !i_out_stall && !load) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_rgb   <= i_in_data;
                        r_en    <= {last && eol, last && (r_col != '0), r_row != '0};
                        if (last && eol) begin
                            r_lastidx <= 2'd2;
                        end else if (last && (r_col != '0)) begin
                            r_lastidx <= 2'd1;
                        end else begin
                            r_lastidx <= 2'd0;
                        end
                        r_state <= S_LUMA;
                    end
                end
                S_LUMA: begin
                    r_lum   <= lum;
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_pc    <= prior_q;
                    r_oc    <= older_q;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_pl    <= prior_q;
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_pr    <= prior_q;
                    r_eidx  <= 2'd0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_en[r_eidx]) begin
                        r_state <= S_WAIT;
                    end else if (r_eidx == 2'd2) begin
                        r_state <= S_WR1;
                    end else begin
                        r_eidx <= r_eidx + 2'd1;
                    end
                end
                S_WAIT: begin
                    if (norm_done) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (load) begin
                        r_ovalid         <= 1'b1;
                        r_out.normal_x   <= norm_codes.normal_x;
                        r_out.normal_y   <= norm_codes.normal_y;
                        r_out.normal_z   <= norm_codes.normal_z;
                        r_out.out_column <= OUT_COL_W'(op_col);
                        r_out.out_row    <= op_row;
                        r_out.run_last   <= r_eidx == r_lastidx;
                        if (r_eidx == 2'd2) begin
                            r_state <= S_WR1;
                        end else begin
                            r_eidx  <= r_eidx + 2'd1;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_WR1: begin
                    r_state <= S_WR2;
                end
                S_WR2: begin
                    if (eol) begin
                        r_w0  <= '0;
                        r_w1  <= '0;
                        r_col <= '0;
                        r_row <= last ? '0 : r_row + OUT_ROW_W'(1);
                    end else begin
                        r_w1  <= r_w0;
                        r_w0  <= r_lum;
                        r_col <= r_col + AW'(1);
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_LUMA)
        else $error("accepted beat did not start luma stage");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        norm_done |-> r_state == S_WAIT)
        else $error("normalize unit finished outside wait state");

    a_idle_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !norm_busy)
        else $error("normalize unit busy while idle");

    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        norm_start |-> !norm_busy)
        else $error("normalize unit started while busy");

endmodule

`default_nettype wire

// ===== rtl/lnmg_ram.sv =====
`default_nettype none

module lnmg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/lnmg_norm.sv =====
`default_nettype none

module lnmg_norm #(
    parameter int LUMA_FRAC_BITS = lnmg_pkg::LUMA_FRAC_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [LUMA_FRAC_BITS-1:0] i_left,
    input  wire logic [LUMA_FRAC_BITS-1:0] i_right,
    input  wire logic [LUMA_FRAC_BITS-1:0] i_up,
    input  wire logic [LUMA_FRAC_BITS-1:0] i_down,
    input  wire logic [lnmg_pkg::GAIN_W-1:0] i_gain,
    output logic                           o_busy,
    output logic                           o_done,
    output lnmg_pkg::t_codes               o_codes
);
    import lnmg_pkg::*;

    localparam int LW  = LUMA_FRAC_BITS;
    localparam int SH  = LW - 12;
    localparam int SHR = (SH > 0) ? SH : 0;
    localparam int SHL = (SH < 0) ? -SH : 0;
    localparam int PW  = LW + 9 + SHL;
    localparam logic [PW-1:0] RND = (SHR > 0) ? (PW'(1) << ((SHR > 0) ? SHR - 1 : 0)) : '0;

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_ADD, S_SQRT, S_DLOAD, S_DIV, S_ENC
    } t_state;

    function automatic logic [VEC_W-1:0] scale_mag(input logic [LW-1:0] a,
                                                    input logic [LW-1:0] b,
                                                    input logic [GAIN_W-1:0] g);
        logic [LW-1:0]   d;
        logic [LW+7:0]   m;
        logic [PW-1:0]   p;
        d = (a < b) ? b - a : a - b;
        m = (LW+8)'(d) * (LW+8)'(g);
        p = PW'(m) + RND;
        return VEC_W'((p >> SHR) << SHL);
    endfunction

    t_state             r_state;
    logic [VEC_W-1:0]   r_ax, r_ay;
    logic               r_sx, r_sy;
    logic [2*VEC_W-1:0] r_sq;
    logic [RAD_W-1:0]   r_sum, r_rad;
    logic [LEN_W:0]     r_rem;
    logic [LEN_W-1:0]   r_root;
    logic [4:0]         r_cnt;
    logic [1:0]         r_k;
    logic [LEN_W:0]     r_drem;
    logic [16:0]        r_dlow;
    logic [Q_W-1:0]     r_q;
    logic [7:0]         r_cx, r_cy, r_cz;
    logic               r_done;

    logic [LEN_W+2:0]   sq_rem2;
    logic [LEN_W+1:0]   sq_trial;
    logic               sq_take;
    logic [LEN_W+1:0]   dv_rem2;
    logic [LEN_W+1:0]   dv_div;
    logic               dv_take;
    logic [VEC_W-1:0]   dv_mag;
    logic               dv_neg;
    logic [Q_W:0]       enc_t;
    logic [25:0]        enc_sum;

    always_comb begin
        sq_rem2  = {r_rem, r_rad[RAD_W-1 -: 2]};
        sq_trial = {r_root, 2'b01};
        sq_take  = sq_rem2 >= {1'b0, sq_trial};
        dv_div   = {1'b0, r_root, 1'b0};
        // partial remainder stays below 2*len, which can need all its bits
        dv_rem2  = {r_drem, r_dlow[16]};
        dv_take  = dv_rem2 >= dv_div;
        case (r_k)
            2'd0:    begin dv_mag = r_ax;          dv_neg = r_sx; end
            2'd1:    begin dv_mag = r_ay;          dv_neg = r_sy; end
            default: begin dv_mag = VEC_W'(65536); dv_neg = 1'b0; end
        endcase
        enc_t   = dv_neg ? (Q_W+1)'(65536) - (Q_W+1)'(r_q)
                         : (Q_W+1)'(65536) + (Q_W+1)'(r_q);
        enc_sum = {enc_t, 8'b0} - 26'(enc_t) + 26'd65536;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_ax    <= scale_mag(i_left, i_right, i_gain);
                        r_sx    <= i_left < i_right;
                        r_ay    <= scale_mag(i_up, i_down, i_gain);
                        r_sy    <= i_up < i_down;
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_sq    <= (2*VEC_W)'(r_ax) * (2*VEC_W)'(r_ax);
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_sum   <= RAD_W'(r_sq) + (RAD_W'(1) << 32);
                    r_sq    <= (2*VEC_W)'(r_ay) * (2*VEC_W)'(r_ay);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_rad   <= r_sum + RAD_W'(r_sq);
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    // one result bit per step, two radicand bits in
                    if (sq_take) begin
                        r_rem  <= (LEN_W+1)'(sq_rem2 - {1'b0, sq_trial});
                        r_root <= {r_root[LEN_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= (LEN_W+1)'(sq_rem2);
                        r_root <= {r_root[LEN_W-2:0], 1'b0};
                    end
                    r_rad <= r_rad << 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(LEN_W - 1)) begin
                        r_k     <= 2'd0;
                        r_state <= S_DLOAD;
                    end
                end
                S_DLOAD: begin
                    // (mag*2^17 + len) / (2*len): upper part starts below divisor
                    r_drem  <= (LEN_W+1)'(dv_mag) + (LEN_W+1)'(r_root[LEN_W-1:17]);
                    r_dlow  <= r_root[16:0];
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (dv_take) begin
                        r_drem <= (LEN_W+1)'(dv_rem2 - dv_div);
                    end else begin
                        r_drem <= (LEN_W+1)'(dv_rem2);
                    end
                    r_q    <= {r_q[Q_W-2:0], dv_take};
                    r_dlow <= r_dlow << 1;
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'(Q_W - 1)) begin
                        r_state <= S_ENC;
                    end
                end
                S_ENC: begin
                    case (r_k)
                        2'd0:    r_cx <= enc_sum[24:17];
                        2'd1:    r_cy <= enc_sum[24:17];
                        default: r_cz <= enc_sum[24:17];
                    endcase
                    if (r_k == 2'd2) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_DLOAD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy  = r_state != S_IDLE;
    assign o_done  = r_done;
    assign o_codes = '{normal_x: r_cx, normal_y: r_cy, normal_z: r_cz};

endmodule

`default_nettype wire

// ===== dv/luminance_normal_map_generator_tb.sv =====
`default_nettype none

module luminance_normal_map_generator_tb;
    import lnmg_pkg::*;

    localparam int SETTLE_CYCLES = 600;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        bit         has_expect;
        logic [7:0] exp_x;
        logic [7:0] exp_y;
        logic [7:0] exp_z;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_pixel_in             i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_pixel_out            o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    luminance_normal_map_generator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [15:0] older_luma [MAX_WIDTH_DEF];
    logic [15:0] prior_luma [MAX_WIDTH_DEF];
    logic [15:0] win0, win1;
    int unsigned col_cnt, row_cnt;
    int unsigned cur_width = 256, cur_height = 256, cur_gain = 48;

    t_pixel_out normal_queue[$];
    t_codes     pinned_codes[$];
    bit         pinned_valid[$];
    int         errors = 0;
    int         beats_in = 0, beats_out = 0;
    int         idle_cycles = 0;
    bit         hold_off = 1'b0;
    bit         timed_out = 1'b0;

    function automatic logic [15:0] luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        longint unsigned p, v;
        p = (64'd13933 * r + 64'd46871 * g + 64'd4732 * b) * 64'd257;
        v = (p + 64'd32768) >> 16;
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic longint gain_diff(logic [15:0] a, logic [15:0] b);
        longint unsigned mag;
        mag = ((a < b) ? longint'(b - a) : longint'(a - b)) * cur_gain;
        mag = (mag + 8) >> 4;
        return (a < b) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [7:0] code_of(longint v, longint unsigned len);
        longint unsigned mag;
        longint q, n, e;
        mag = (v < 0) ? -v : v;
        q = (mag * 131072 + len) / (2 * len);
        n = (v < 0) ? -q : q;
        e = ((n + 65536) * 255 + 65536) >>> 17;
        if (e < 0) e = 0;
        if (e > 255) e = 255;
        return e[7:0];
    endfunction

    function automatic t_pixel_out normal_at(logic [15:0] lf, logic [15:0] rt, logic [15:0] up,
                                             logic [15:0] dn, int unsigned c, int unsigned r);
        t_pixel_out o;
        longint vx, vy;
        longint unsigned ax, ay, len;
        vx = gain_diff(lf, rt);
        vy = gain_diff(up, dn);
        ax = (vx < 0) ? -vx : vx;
        ay = (vy < 0) ? -vy : vy;
        len = root_floor(ax * ax + ay * ay + (64'd1 << 32));
        o.normal_x = code_of(vx, len);
        o.normal_y = code_of(vy, len);
        o.normal_z = code_of(65536, len);
        o.out_column = c[OUT_COL_W-1:0];
        o.out_row = r[OUT_ROW_W-1:0];
        o.run_last = 1'b0;
        return o;
    endfunction

    // returns number of normals queued for this pixel
    function automatic int predict_pixel(t_pixel_in px);
        int unsigned c, r, ew, eh, lc, rc;
        logic [15:0] lum, up, lf;
        bit eol, last;
        t_pixel_out res[$];
        c = col_cnt;
        r = row_cnt;
        ew = (cur_width < 2) ? 2 : ((cur_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cur_width);
        eh = (cur_height < 2) ? 2 : ((cur_height > MAX_HEIGHT) ? MAX_HEIGHT : cur_height);
        lum = luma_of(px.red, px.green, px.blue);
        eol = (c >= ew - 1);
        last = (r >= eh - 1);
        if (r >= 1) begin
            lc = (c == 0) ? 0 : c - 1;
            rc = (c + 1 > ew - 1) ? ew - 1 : c + 1;
            up = (r == 1) ? prior_luma[c] : older_luma[c];
            res.push_back(normal_at(prior_luma[lc], prior_luma[rc], up, lum, c, r - 1));
        end
        if (last && c >= 1) begin
            lf = (c == 1) ? win0 : win1;
            res.push_back(normal_at(lf, lum, prior_luma[c - 1], win0, c - 1, r));
        end
        if (last && eol) begin
            lf = (c == 0) ? lum : win0;
            res.push_back(normal_at(lf, lum, prior_luma[c], lum, c, r));
        end
        if (c >= 1) begin
            older_luma[c - 1] = prior_luma[c - 1];
            prior_luma[c - 1] = win0;
        end
        if (eol) begin
            older_luma[c] = prior_luma[c];
            prior_luma[c] = lum;
            win0 = '0;
            win1 = '0;
            col_cnt = 0;
            row_cnt = last ? 0 : r + 1;
        end else begin
            win1 = win0;
            win0 = lum;
            col_cnt = c + 1;
        end
        if (res.size() > 0) res[res.size() - 1].run_last = 1'b1;
        foreach (res[i]) normal_queue.push_back(res[i]);
        return res.size();
    endfunction

    // input side monitor: predicts on each accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            void'(predict_pixel(i_in_data));
            beats_in++;
        end
    end

    // output side checker
    always @(posedge i_clk) begin
        t_pixel_out want;
        t_codes pin;
        bit has_pin;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_out++;
            if (normal_queue.size() == 0) begin
                $error("unexpected normal beat col=%0d row=%0d",
                       o_out_data.out_column, o_out_data.out_row);
                errors++;
            end else begin
                want = normal_queue.pop_front();
                has_pin = 1'b0;
                if (pinned_valid.size() > 0) begin
                    has_pin = pinned_valid.pop_front();
                    pin = pinned_codes.pop_front();
                end
                if (has_pin && (pin.normal_x != want.normal_x ||
                    pin.normal_y != want.normal_y || pin.normal_z != want.normal_z)) begin
                    $error("predictor disagrees with table value %p vs %p", pin, want);
                    errors++;
                end
                if (o_out_data.normal_x !== want.normal_x) begin
                    $error("normal_x expected %0d got %0d", want.normal_x, o_out_data.normal_x);
                    errors++;
                end
                if (o_out_data.normal_y !== want.normal_y) begin
                    $error("normal_y expected %0d got %0d", want.normal_y, o_out_data.normal_y);
                    errors++;
                end
                if (o_out_data.normal_z !== want.normal_z) begin
                    $error("normal_z expected %0d got %0d", want.normal_z, o_out_data.normal_z);
                    errors++;
                end
                if (o_out_data.out_column !== want.out_column) begin
                    $error("out_column expected %0d got %0d", want.out_column,
                           o_out_data.out_column);
                    errors++;
                end
                if (o_out_data.out_row !== want.out_row) begin
                    $error("out_row expected %0d got %0d", want.out_row, o_out_data.out_row);
                    errors++;
                end
                if (o_out_data.run_last !== want.run_last) begin
                    $error("run_last expected %0d got %0d", want.run_last,
                           o_out_data.run_last);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        int unsigned phase;
        phase = $urandom_range(0, 15);
        if (hold_off) i_out_stall <= 1'b1;
        else if (beats_in < 60) i_out_stall <= 1'b0;
        else i_out_stall <= (phase < 5);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out <= 1'b1;
        end
    end

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IMAGE_WIDTH: cur_width = value & 32'hFFF;
            CFG_IMAGE_HEIGHT: cur_height = value & 32'h1FFF;
            default: cur_gain = value & 32'hFF;
        endcase
    endtask

    task automatic drain();
        while (normal_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(int unsigned w, int unsigned h, int unsigned g);
        drain();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_GRADIENT_GAIN, g);
        i_cfg_valid <= 1'b0;
    endtask

    // one beat on the pixel channel; valid stays low for the gap before it
    task automatic send_pixel(t_pixel_in px, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= px;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_image(int unsigned w, int unsigned h, bit flat_only);
        t_pixel_in px;
        int burst;
        burst = 0;
        for (int i = 0; i < w * h; i++) begin
            if (flat_only) begin
                px = '{8'd128, 8'd128, 8'd128};
            end else begin
                case ($urandom_range(0, 5))
                    0: px = '{8'd0, 8'd0, 8'd0};
                    1: px = '{8'hFF, 8'hFF, 8'hFF};
                    default: px = t_pixel_in'(24'($urandom()));
                endcase
            end
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                send_pixel(px, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
            end else begin
                send_pixel(px, 0);
            end
            burst--;
        end
        i_in_valid <= 1'b0;
    endtask

    t_dir_row dir_rows[$];
    int hold_count;
    int random_items;
    int imgw, imgh;

    initial begin
        for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
            older_luma[i] = '0;
            prior_luma[i] = '0;
        end
        win0 = '0;
        win1 = '0;
        col_cnt = 0;
        row_cnt = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 3x3 image, extremes; checked against the predictor, no pinned values
        configure(3, 3, 255);
        dir_rows = '{
            '{8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
            '{8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
            '{8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
            '{8'd255, 8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
            '{8'd0,   8'd255, 8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
            '{8'd0,   8'd0,   8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
            '{8'd170, 8'd85,  8'd15,  1'b0, 8'd0,   8'd0,   8'd0},
            '{8'd85,  8'd170, 8'd240, 1'b0, 8'd0,   8'd0,   8'd0},
            '{8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0}
        };
        foreach (dir_rows[i]) begin
            send_pixel('{dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue}, 0);
        end
        i_in_valid <= 1'b0;
        drain();
        // flat image with gain 1: every normal is straight up
        configure(2, 2, 1);
        for (int i = 0; i < 4; i++) begin
            send_pixel('{8'd77, 8'd77, 8'd77}, 0);
            // row 0 gives nothing; the last row gives 1, then 3 normals
            repeat ((i < 2) ? 0 : ((i == 2) ? 1 : 3)) begin
                pinned_valid.push_back(1'b1);
                pinned_codes.push_back('{8'd128, 8'd128, 8'd255});
            end
        end
        i_in_valid <= 1'b0;
        // align pins: directed 3x3 image already consumed its slots unpinned
        drain();
        // out-of-range registers: zero gain, width and height below minimum
        configure(0, 1, 0);
        for (int i = 0; i < 4; i++) begin
            send_pixel(t_pixel_in'(24'($urandom())), 0);
            repeat ((i < 2) ? 0 : ((i == 2) ? 1 : 3)) begin
                pinned_valid.push_back(1'b1);
                pinned_codes.push_back('{8'd128, 8'd128, 8'd255});
            end
        end
        i_in_valid <= 1'b0;
        drain();

        // long receiver hold-off while the sender keeps offering
        configure(8, 4, 48);
        hold_off = 1'b1;
        fork
            begin
                hold_count = 0;
                while (hold_count < 2000) begin
                    @(posedge i_clk);
                    hold_count++;
                end
                hold_off = 1'b0;
            end
            send_image(8, 4, 1'b0);
        join
        drain();

        random_items = 0;
        while (random_items < 360) begin
            case ($urandom_range(0, 4))
                0: begin imgw = 2; imgh = 2; end
                1: begin imgw = $urandom_range(2, 12); imgh = $urandom_range(2, 6); end
                2: begin imgw = $urandom_range(20, 40); imgh = 3; end
                default: begin imgw = $urandom_range(3, 8); imgh = $urandom_range(2, 4); end
            endcase
            configure(imgw, imgh, ($urandom_range(0, 3) == 0) ?
                      (($urandom_range(0, 1) == 0) ? 1 : 255) : $urandom_range(1, 255));
            send_image(imgw, imgh, 1'b0);
            random_items += imgw * imgh;
        end

        drain();
        $display("covered %0d pixels in, %0d normals out, widths 2..40, gains 0..255",
                 beats_in, beats_out);
        if (errors == 0 && normal_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        wait (timed_out);
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/lnmg_pkg.sv
rtl/lnmg_ram.sv
rtl/lnmg_norm.sv
rtl/luminance_normal_map_generator.sv
dv/luminance_normal_map_generator_tb.sv
